// File: src/upe_pkg.sv
// Shared types, constants and byte-class functions for the URL percent encoder.
// Used by upe_expand and url_percent_encoder; depends on nothing else.
package upe_pkg;

  localparam int MaxOut = 7;
  localparam int CntW   = 3;

  localparam logic [7:0] Pct = 8'h25;

  typedef enum logic [1:0] {
    PendNone  = 2'd0,
    PendPct   = 2'd1,
    PendDigit = 2'd2
  } pend_t;

  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [CntW-1:0]        cnt;
    pend_t                  pend;
    logic [7:0]             held;
  } enc_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    is_hex = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
             (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic is_unsafe(input logic [7:0] b);
    logic r;
    r = (b < 8'h20) || (b >= 8'h7f);
    case (b)
      8'h20, 8'h22, 8'h23, 8'h25, 8'h3c, 8'h3e, 8'h3a, 8'h40,
      8'h5b, 8'h5c, 8'h5d, 8'h5e, 8'h60, 8'h7b, 8'h7c, 8'h7d: r = 1'b1;
      default: r = r;
    endcase
    is_unsafe = r;
  endfunction

  function automatic logic is_reserved(input logic [7:0] b);
    logic r;
    case (b)
      8'h23, 8'h24, 8'h26, 8'h2b, 8'h2c, 8'h2f, 8'h3a,
      8'h3b, 8'h3d, 8'h3f, 8'h40, 8'h5b, 8'h5d: r = 1'b1;
      default: r = 1'b0;
    endcase
    is_reserved = r;
  endfunction

  function automatic logic needs_escape(input logic [7:0] b, input logic mode);
    if (mode) begin
      needs_escape = is_unsafe(b) || is_reserved(b);
    end else begin
      needs_escape = is_unsafe(b) && !is_reserved(b);
    end
  endfunction

endpackage

// File: src/upe_expand.sv
// Combinational expansion of one raw byte into up to seven encoded bytes,
// given the held-back percent state. Depends on upe_pkg.
module upe_expand (
  input  logic [7:0]    data_i,
  input  logic          last_i,
  input  logic          mode_i,
  input  upe_pkg::pend_t pend_i,
  input  logic [7:0]    held_i,
  output upe_pkg::enc_t enc_o
);

  always_comb begin
    logic [3:0][7:0] p;
    logic [2:0][7:0] f;
    logic [2:0]      plen;
    logic [1:0]      flen;
    logic            use_f;
    upe_pkg::pend_t  f_pend;
    logic [2:0]      j;

    p      = '0;
    f      = '0;
    plen   = 3'd0;
    flen   = 2'd0;
    use_f  = 1'b1;
    f_pend = upe_pkg::PendNone;
    j      = 3'd0;
    enc_o  = '0;
    enc_o.held = held_i;

    // byte handled with nothing held
    if (data_i == upe_pkg::Pct) begin
      if (last_i) begin
        f[0] = upe_pkg::Pct;
        f[1] = upe_pkg::hex_char(upe_pkg::Pct[7:4]);
        f[2] = upe_pkg::hex_char(upe_pkg::Pct[3:0]);
        flen = 2'd3;
      end else begin
        f_pend = upe_pkg::PendPct;
      end
    end else if (upe_pkg::needs_escape(data_i, mode_i)) begin
      f[0] = upe_pkg::Pct;
      f[1] = upe_pkg::hex_char(data_i[7:4]);
      f[2] = upe_pkg::hex_char(data_i[3:0]);
      flen = 2'd3;
    end else begin
      f[0] = data_i;
      flen = 2'd1;
    end

    case (pend_i)
      upe_pkg::PendPct: begin
        if (upe_pkg::is_hex(data_i) && !last_i) begin
          use_f      = 1'b0;
          enc_o.held = data_i;
        end else begin
          p[0] = upe_pkg::Pct;
          p[1] = upe_pkg::hex_char(upe_pkg::Pct[7:4]);
          p[2] = upe_pkg::hex_char(upe_pkg::Pct[3:0]);
          plen = 3'd3;
        end
      end
      upe_pkg::PendDigit: begin
        if (upe_pkg::is_hex(data_i)) begin
          // valid escape: pass it through untouched
          p[0]  = upe_pkg::Pct;
          p[1]  = held_i;
          p[2]  = data_i;
          plen  = 3'd3;
          use_f = 1'b0;
        end else begin
          p[0] = upe_pkg::Pct;
          p[1] = upe_pkg::hex_char(upe_pkg::Pct[7:4]);
          p[2] = upe_pkg::hex_char(upe_pkg::Pct[3:0]);
          p[3] = held_i;
          plen = 3'd4;
        end
      end
      default: begin
        plen = 3'd0;
      end
    endcase

    if (use_f) begin
      enc_o.pend = f_pend;
    end else if (pend_i == upe_pkg::PendPct && !(last_i) && upe_pkg::is_hex(data_i)) begin
      enc_o.pend = upe_pkg::PendDigit;
    end else begin
      enc_o.pend = upe_pkg::PendNone;
    end

    for (int i = 0; i < upe_pkg::MaxOut; i++) begin
      j = 3'(i) - plen;
      if (3'(i) < plen) begin
        enc_o.bytes[i] = p[j[1:0] + 2'(i) - j[1:0]];
      end else if (use_f && j < {1'b0, flen}) begin
        enc_o.bytes[i] = f[j[1:0]];
      end
    end

    enc_o.cnt = plen + (use_f ? {1'b0, flen} : 3'd0);
  end

endmodule

// File: src/url_percent_encoder.sv
// Top level of the URL percent encoder: input register, expansion buffer and
// output handshake. Depends on upe_pkg and upe_expand.

// Streaming URL percent encoder. Each input word carries one raw byte
// (in_tdata[7:0]) and in_tlast marking the final byte of a string. It leaves as
// zero to seven output words of one byte each, one word per cycle while
// out_tready is high: a plain byte gives one word, an escaped byte three, a "%"
// is held back until the next byte decides whether it starts a valid escape,
// and the word marked last flushes everything held. The output port rate (one
// byte per cycle while out_tready is high) sets the throughput; an input register
// holds each word until the run buffer is free, so a new word can be taken while
// the previous run still drains. cfg_wr_en/cfg_wr_data[0] set the query mode
// (1 also escapes reserved characters); write it only while idle.
module url_percent_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // end_of_run
  output logic       out_tuser   // [0] end_of_string
);

  logic                                mode_r;
  logic                                in_v_r;
  logic [7:0]                          in_data_r;
  logic                                in_last_r;
  upe_pkg::pend_t                      pend_r;
  logic [7:0]                          held_r;
  logic                                run_v_r;
  logic [upe_pkg::MaxOut-1:0][7:0]     run_bytes_r;
  logic [upe_pkg::CntW-1:0]            rem_r;
  logic                                run_last_r;

  upe_pkg::enc_t enc;
  logic          take;
  logic          run_done;
  logic          run_free;
  logic          load;

  upe_expand u_expand (
    .data_i (in_data_r),
    .last_i (in_last_r),
    .mode_i (mode_r),
    .pend_i (pend_r),
    .held_i (held_r),
    .enc_o  (enc)
  );

  assign take     = run_v_r && out_tready;
  assign run_done = take && (rem_r == upe_pkg::CntW'(1));
  assign run_free = !run_v_r || run_done;
  assign load     = in_v_r && run_free;
  assign in_tready = !in_v_r || load;

  assign out_tvalid = run_v_r;
  assign out_tdata  = run_bytes_r[0];
  assign out_tlast  = (rem_r == upe_pkg::CntW'(1));
  assign out_tuser  = run_last_r && (rem_r == upe_pkg::CntW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      in_v_r  <= 1'b0;
      pend_r  <= upe_pkg::PendNone;
      held_r  <= 8'd0;
      run_v_r <= 1'b0;
      rem_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (in_tvalid && in_tready) begin
        in_v_r <= 1'b1;
      end else if (load) begin
        in_v_r <= 1'b0;
      end
      if (load) begin
        pend_r  <= enc.pend;
        held_r  <= enc.held;
        run_v_r <= (enc.cnt != '0);
        rem_r   <= enc.cnt;
      end else if (take) begin
        run_v_r <= !run_done;
        rem_r   <= rem_r - upe_pkg::CntW'(1);
      end
    end
  end

  // payload: capture on accept, shift down as bytes leave
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (load) begin
      run_bytes_r <= enc.bytes;
      run_last_r  <= in_last_r;
    end else if (take) begin
      run_bytes_r <= {8'd0, run_bytes_r[upe_pkg::MaxOut-1:1]};
    end
  end

  a_valid_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (rem_r != '0))
    else $error("output valid with empty run");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= upe_pkg::CntW'(upe_pkg::MaxOut))
    else $error("run length exceeds maximum");

  a_pend_code: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != upe_pkg::pend_t'(2'd3))
    else $error("unused pending code reached");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !load) |=> (in_v_r && $stable(in_data_r)))
    else $error("input word lost while blocked");

  a_done_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (run_done && !load) |=> !run_v_r)
    else $error("run not released after last byte");

endmodule

// File: tb/testbench.sv
// Self-checking bench for url_percent_encoder: random and directed byte strings,
// a behavioral encoder that predicts every output word, and an in-order checker.
// Depends on upe_pkg and the url_percent_encoder RTL.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } raw_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
    logic       str_end;
  } enc_word_t;

  localparam string HexUpper   = "0123456789ABCDEF";
  localparam string HexPool    = "0123456789abcdefABCDEF";
  localparam string ReservedCh = "#$&+,/:;=?@[]";
  localparam string UnsafeCh   = " \"#%<>:@[\\]^`{|}";

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  raw_byte_t  raw_q[$];
  enc_word_t  enc_expect[$];
  logic [7:0] enc_run[$];

  // encoder state as the block should hold it
  logic           query_mode = 1'b0;
  upe_pkg::pend_t pct_state = upe_pkg::PendNone;
  logic [7:0]     held_char = 8'h00;

  logic in_took = 1'b0;
  int   idle_pct = 38;
  int   errors = 0;
  int   bytes_in = 0;
  int   words_out = 0;
  int   strings_out = 0;

  url_percent_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit in_set(string s, logic [7:0] b);
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit wants_escape(logic [7:0] b);
    bit unsafe;
    bit rsvd;
    unsafe = (b < 8'h20) || (b >= 8'h7f) || in_set(UnsafeCh, b);
    rsvd   = in_set(ReservedCh, b);
    return query_mode ? (unsafe || rsvd) : (unsafe && !rsvd);
  endfunction

  // append one byte to the run being predicted
  task automatic put_char(logic [7:0] b);
    enc_run = {enc_run, b};
  endtask

  task automatic push_escape(logic [7:0] b);
    put_char(upe_pkg::Pct);
    put_char(HexUpper[b[7:4]]);
    put_char(HexUpper[b[3:0]]);
  endtask

  // a byte seen with nothing held back
  task automatic take_fresh(logic [7:0] b, logic last);
    if (b == upe_pkg::Pct) begin
      if (last) push_escape(b);
      else pct_state = upe_pkg::PendPct;
    end else if (wants_escape(b)) begin
      push_escape(b);
    end else begin
      put_char(b);
    end
  endtask

  task automatic encode_byte(logic [7:0] b, logic last);
    upe_pkg::pend_t was;
    enc_word_t      w;
    was = pct_state;
    pct_state = upe_pkg::PendNone;
    enc_run.delete();
    case (was)
      upe_pkg::PendPct: begin
        if (in_set(HexPool, b) && !last) begin
          pct_state = upe_pkg::PendDigit;
          held_char = b;
        end else begin
          push_escape(upe_pkg::Pct);
          take_fresh(b, last);
        end
      end
      upe_pkg::PendDigit: begin
        if (in_set(HexPool, b)) begin
          put_char(upe_pkg::Pct);
          put_char(held_char);
          put_char(b);
        end else begin
          push_escape(upe_pkg::Pct);
          put_char(held_char);
          take_fresh(b, last);
        end
      end
      default: take_fresh(b, last);
    endcase
    foreach (enc_run[i]) begin
      w.ch      = enc_run[i];
      w.run_end = (i == enc_run.size() - 1);
      w.str_end = w.run_end && last;
      enc_expect = {enc_expect, w};
    end
  endtask

  // predict on input words, check output words
  always @(posedge clk) begin : monitor
    enc_word_t w;
    in_took <= in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_wr_en) query_mode = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        encode_byte(in_tdata, in_tlast);
        bytes_in++;
      end
      if (out_tvalid && out_tready) begin
        words_out++;
        if (enc_expect.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, got byte %h eor %b eos %b",
                   $time, out_tdata, out_tlast, out_tuser);
        end else begin
          w = enc_expect.pop_front();
          if (w.str_end) strings_out++;
          if (out_tdata !== w.ch) begin
            errors++;
            $display("%0t: out_byte expected %h got %h", $time, w.ch, out_tdata);
          end
          if (out_tlast !== w.run_end) begin
            errors++;
            $display("%0t: end_of_run expected %b got %b", $time, w.run_end, out_tlast);
          end
          if (out_tuser !== w.str_end) begin
            errors++;
            $display("%0t: end_of_string expected %b got %b", $time, w.str_end, out_tuser);
          end
        end
      end
    end
  end

  // drive on the falling edge; hold a word until it is taken
  always @(negedge clk) begin : driver
    raw_byte_t nxt;
    if (rst_n && (!in_tvalid || in_took)) begin
      if (raw_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        nxt = raw_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nxt.data;
        in_tlast  <= nxt.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= rst_n && ($urandom_range(0, 99) >= idle_pct);
  end

  task automatic add_byte(logic [7:0] b, logic last);
    raw_byte_t r;
    r.data = b;
    r.last = last;
    raw_q = {raw_q, r};
  endtask

  task automatic add_text(string s, logic last);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1:    return 8'($urandom_range(0, 255));
      2, 3:    return upe_pkg::Pct;
      4, 5:    return HexPool[$urandom_range(0, HexPool.len() - 1)];
      6:       return ReservedCh[$urandom_range(0, ReservedCh.len() - 1)];
      7:       return UnsafeCh[$urandom_range(0, UnsafeCh.len() - 1)];
      default: return 8'($urandom_range(8'h61, 8'h7a));
    endcase
  endfunction

  // one string of random length; some slots get a well-formed escape triplet
  task automatic add_random_string();
    int len;
    int k;
    len = $urandom_range(1, 10);
    k = 0;
    while (k < len) begin
      if ($urandom_range(0, 3) == 0 && k + 3 <= len) begin
        add_byte(upe_pkg::Pct, 1'b0);
        add_byte(HexPool[$urandom_range(0, HexPool.len() - 1)], 1'b0);
        add_byte(HexPool[$urandom_range(0, HexPool.len() - 1)], k + 3 == len);
        k += 3;
      end else begin
        add_byte(pick_byte(), k + 1 == len);
        k++;
      end
    end
  endtask

  task automatic drain();
    while (raw_q.size() > 0 || in_tvalid || enc_expect.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_mode(logic m);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : stimulus
    int start;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_mode(1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(8'h7f, 1'b0);
    add_text(" a#/%4a%z%B!%%3F%7", 1'b1);
    add_text("%", 1'b1);
    add_text("%ab", 1'b1);

    for (int p = 0; p < 4; p++) begin
      set_mode(p[0] ? 1'b0 : 1'b1);
      idle_pct = (p == 1) ? 0 : 38;
      start = bytes_in + raw_q.size();
      while (bytes_in + raw_q.size() - start < 36) add_random_string();
    end

    drain();
    $display("%0d raw bytes in %0d strings encoded, %0d output words checked",
             bytes_in, strings_out, words_out);
    $display("both query modes, with and without idle cycles on each side");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("timeout waiting for the encoder");
    $display("simulation failed");
    $finish;
  end

endmodule
